>>> hw/rtl/vmt_pkg.sv
// vmt_pkg: shared types, mode codes and register indexes for the vertex transform
// no dependencies
package vmt_pkg;

  localparam int CoordW = 32;   // q16.16 vector component
  localparam int CoefW  = 16;   // q2.14 matrix coefficient
  localparam int RowW   = 64;   // four packed coefficients
  localparam int NumLn  = 4;    // one lane per result column
  localparam int AccW   = 64;   // exact q.32 accumulator
  localparam int RndW   = AccW - 16;  // rounded q.16 before saturation

  typedef logic [1:0] func_t;
  localparam func_t FuncFull   = 2'd0;
  localparam func_t FuncRotate = 2'd1;
  localparam func_t FuncAffine = 2'd2;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgRow0   = 3'd0;
  localparam cfg_idx_t CfgRow1   = 3'd1;
  localparam cfg_idx_t CfgRow2   = 3'd2;
  localparam cfg_idx_t CfgTransX = 3'd3;
  localparam cfg_idx_t CfgTransY = 3'd4;
  localparam cfg_idx_t CfgTransZ = 3'd5;
  localparam cfg_idx_t CfgWCoef  = 3'd6;

  // stage enables handed from the top level pipeline control to the lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

endpackage

>>> hw/rtl/vmt_lane.sv
// vmt_lane: one result column, four products then exact sum and half-up rounding
// depends on vmt_pkg
module vmt_lane (
  input  logic                                clk,
  input  vmt_pkg::lane_ctl_t                  ctl,
  input  logic                                col_w,    // lane computes the w column
  input  vmt_pkg::func_t                      func_s1,  // mode of the word in stage 1
  input  logic signed [vmt_pkg::CoordW-1:0]   vx,
  input  logic signed [vmt_pkg::CoordW-1:0]   vy,
  input  logic signed [vmt_pkg::CoordW-1:0]   vz,
  input  logic signed [vmt_pkg::CoordW-1:0]   vw,
  input  logic signed [vmt_pkg::CoefW-1:0]    c0,
  input  logic signed [vmt_pkg::CoefW-1:0]    c1,
  input  logic signed [vmt_pkg::CoefW-1:0]    c2,
  input  logic signed [vmt_pkg::CoordW-1:0]   trans,
  input  logic signed [vmt_pkg::CoefW-1:0]    wcoef,
  output logic signed [vmt_pkg::RndW-1:0]     rnd_r
);
  import vmt_pkg::*;

  localparam int PW = CoordW + CoefW;

  logic signed [PW-1:0]     p0_r, p1_r, p2_r;
  logic signed [AccW-1:0]   p3_r;
  logic signed [CoordW-1:0] m3;
  logic signed [AccW-1:0]   t0, t1, t2, t3, sum;

  // fourth multiplicand: w coefficient in the w lane, translation elsewhere
  assign m3 = col_w ? CoordW'(wcoef) : trans;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      p0_r <= vx * c0;
      p1_r <= vy * c1;
      p2_r <= vz * c2;
      p3_r <= vw * m3;
    end
  end

  // q.30 coefficient products scaled to q.32
  assign t0 = {{(AccW-PW-2){p0_r[PW-1]}}, p0_r, 2'b00};
  assign t1 = {{(AccW-PW-2){p1_r[PW-1]}}, p1_r, 2'b00};
  assign t2 = {{(AccW-PW-2){p2_r[PW-1]}}, p2_r, 2'b00};

  always_comb begin
    t3 = '0;
    case (func_s1)
      FuncFull: begin
        if (col_w) t3 = {p3_r[AccW-3:0], 2'b00};
        else       t3 = p3_r;
      end
      FuncAffine: begin
        // translation added as is, q.16 to q.32
        t3 = {{(AccW-CoordW-16){trans[CoordW-1]}}, trans, 16'h0000};
      end
      default: t3 = '0;
    endcase
  end

  assign sum = t0 + t1 + t2 + t3 + AccW'(32768);

  // floor of sum / 2^16 is its upper bits
  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      rnd_r <= sum[AccW-1:16];
    end
  end

endmodule

>>> hw/rtl/vmt_merge.sv
// vmt_merge: saturates the four lane results, picks w and gathers the overflow flag
// depends on vmt_pkg
module vmt_merge (
  input  logic                               clk,
  input  logic                               en,
  input  vmt_pkg::func_t                     func_s2,
  input  logic signed [vmt_pkg::CoordW-1:0]  w_s2,
  input  logic signed [vmt_pkg::RndW-1:0]    rnd [vmt_pkg::NumLn],
  output logic [4*vmt_pkg::CoordW-1:0]       data_r,
  output logic                               ovf_r
);
  import vmt_pkg::*;

  logic [CoordW-1:0] sat [NumLn];
  logic [NumLn-1:0]  hit;
  logic [CoordW-1:0] w_sel;
  logic              ovf_nxt;

  always_comb begin
    for (int i = 0; i < NumLn; i++) begin
      // in range when all bits above the sign of a 32-bit word agree
      hit[i] = !((&rnd[i][RndW-1:CoordW-1]) || !(|rnd[i][RndW-1:CoordW-1]));
      if (!hit[i])            sat[i] = rnd[i][CoordW-1:0];
      else if (rnd[i][RndW-1]) sat[i] = {1'b1, {(CoordW-1){1'b0}}};
      else                    sat[i] = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_comb begin
    if (func_s2 == FuncFull) begin
      w_sel   = sat[3];
      ovf_nxt = |hit;
    end else begin
      w_sel   = w_s2;
      ovf_nxt = |hit[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= {w_sel, sat[2], sat[1], sat[0]};
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

>>> hw/rtl/vertex_matrix_transform.sv
// vertex_matrix_transform: top level, config registers, four column lanes, merge stage
// depends on vmt_pkg, vmt_lane, vmt_merge
//
// Multiplies a q16.16 row vector (x, y, z, w) by a 4x4 matrix and takes one
// word per clock unless out_tready stalls it. Each word passes, in order:
// stage 1 forms all sixteen products in four column lanes (three 32x16 and one
// 32x32 multiplier per lane), stage 2 sums each column exactly in 64 bits and
// rounds half up to q.16, and stage 3 saturates, picks w and registers the
// output word. Every stage holds its word only while the stage after it is
// full and stalled, so gaps close up and a new word is accepted while a
// finished result waits on out_tready. func 0 runs the full matrix with the
// translation weighted by w, func 1 (and the unused code 3) the 3x3 block
// only, func 2 adds the translation as if w were one; outside func 0, w
// passes through untouched and never flags overflow. Config writes take
// effect at once and must only happen while the pipeline is empty.
module vertex_matrix_transform (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // x_in, y_in, z_in, w_in (32 bits each, x lowest)
  input  logic [1:0]   in_tuser,   // func
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // x_out, y_out, z_out, w_out (32 bits each, x lowest)
  output logic         out_tuser,  // overflow
  // config write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import vmt_pkg::*;

  // config registers, reset to identity
  logic [RowW-1:0]          row_r [3];
  logic signed [CoordW-1:0] trans_r [3];
  logic signed [CoefW-1:0]  wcoef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= RowW'(64'h0000_0000_0000_4000);
      row_r[1]   <= RowW'(64'h0000_0000_4000_0000);
      row_r[2]   <= RowW'(64'h0000_4000_0000_0000);
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
      wcoef_r    <= CoefW'(16'h4000);
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRow0:   row_r[0]   <= cfg_data;
        CfgRow1:   row_r[1]   <= cfg_data;
        CfgRow2:   row_r[2]   <= cfg_data;
        CfgTransX: trans_r[0] <= cfg_data[CoordW-1:0];
        CfgTransY: trans_r[1] <= cfg_data[CoordW-1:0];
        CfgTransZ: trans_r[2] <= cfg_data[CoordW-1:0];
        CfgWCoef:  wcoef_r    <= cfg_data[CoefW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // pipeline valid chain, a stage moves when it is empty or the next one moves
  logic      v1_r, v2_r, v3_r;
  logic      rdy1, rdy2, rdy3;
  lane_ctl_t ctl;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign ctl.s1_en = rdy1;
  assign ctl.s2_en = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // side band carried alongside the lanes: mode and raw w for pass-through
  func_t              func_s1_r, func_s2_r;
  logic signed [CoordW-1:0] w_s1_r, w_s2_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      func_s1_r <= in_tuser;
      w_s1_r    <= in_tdata[4*CoordW-1:3*CoordW];
    end
    if (rdy2) begin
      func_s2_r <= func_s1_r;
      w_s2_r    <= w_s1_r;
    end
  end

  logic signed [CoordW-1:0] vx, vy, vz, vw;
  assign vx = in_tdata[CoordW-1:0];
  assign vy = in_tdata[2*CoordW-1:CoordW];
  assign vz = in_tdata[3*CoordW-1:2*CoordW];
  assign vw = in_tdata[4*CoordW-1:3*CoordW];

  logic signed [RndW-1:0] rnd [NumLn];

  // one lane per column; column 3 multiplies w by the row 3 w coefficient
  for (genvar c = 0; c < NumLn; c++) begin : g_lane
    vmt_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .col_w   ((c == NumLn - 1) ? 1'b1 : 1'b0),
      .func_s1 (func_s1_r),
      .vx      (vx),
      .vy      (vy),
      .vz      (vz),
      .vw      (vw),
      .c0      (row_r[0][CoefW*c +: CoefW]),
      .c1      (row_r[1][CoefW*c +: CoefW]),
      .c2      (row_r[2][CoefW*c +: CoefW]),
      .trans   (trans_r[(c < 3) ? c : 0]),
      .wcoef   (wcoef_r),
      .rnd_r   (rnd[c])
    );
  end

  vmt_merge u_merge (
    .clk     (clk),
    .en      (rdy3),
    .func_s2 (func_s2_r),
    .w_s2    (w_s2_r),
    .rnd     (rnd),
    .data_r  (out_tdata),
    .ovf_r   (out_tuser)
  );

  assign out_tvalid = v3_r;

endmodule

>>> hw/rtl/vmt_checker.sv
// vmt_checker: port-level checks on the vertex transform, bound to the top level
// depends on vertex_matrix_transform ports only
module vmt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser
);

  // reset empties the output stage
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // with nothing waiting at the output the pipeline always takes a word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // overflow only shows with at least one clamped component
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:0]   == 32'h7fff_ffff || out_tdata[31:0]   == 32'h8000_0000 ||
      out_tdata[63:32]  == 32'h7fff_ffff || out_tdata[63:32]  == 32'h8000_0000 ||
      out_tdata[95:64]  == 32'h7fff_ffff || out_tdata[95:64]  == 32'h8000_0000 ||
      out_tdata[127:96] == 32'h7fff_ffff || out_tdata[127:96] == 32'h8000_0000)
    else $error("overflow flag without a clamped component");

endmodule

bind vertex_matrix_transform vmt_checker u_vmt_checker (.*);
